// ----- rtl/interrupt_table_entry_parser_assert.svh -----
// Assertion macros for the parser RTL.
`ifndef INTERRUPT_TABLE_ENTRY_PARSER_ASSERT_SVH
`define INTERRUPT_TABLE_ENTRY_PARSER_ASSERT_SVH

// Same-cycle implication.
`define ITEP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ITEP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/itep_pkg.sv -----
package itep_pkg;

  typedef enum logic [2:0] {
    KIND_BASE = 3'd0,
    KIND_PROC = 3'd1,
    KIND_IOC  = 3'd2,
    KIND_OVR  = 3'd3,
    KIND_END  = 3'd4
  } kind_e;

  localparam logic [7:0] ENTRY_PROC = 8'd0;
  localparam logic [7:0] ENTRY_IOC  = 8'd1;
  localparam logic [7:0] ENTRY_OVR  = 8'd2;

  localparam int LenFirst  = 4;
  localparam int LenLast   = 7;
  localparam int BaseFirst = 36;
  localparam int BaseLast  = 39;
  localparam int WalkStart = 44;
  localparam int MinEntry  = 2;
  localparam int CapBytes  = 12;

  localparam int MaxProcessorsDef    = 64;
  localparam int MaxIoControllersDef = 16;
  localparam int MaxOverridesDef     = 32;

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int LvlW   = $clog2(QDepth + 1);

  typedef logic [CapBytes-1:0][7:0] cap_t;

  typedef struct packed {
    kind_e      kind;
    logic [5:0] slot;
    logic       malformed;
    logic       last;
    cap_t       cap;
  } qrec_t;

  typedef struct packed {
    logic [1:0]      cnt;
    qrec_t [1:0]     rec;
  } push_t;

  typedef struct packed {
    logic [LvlW-1:0] level;
    logic            ready;
    logic            nonempty;
  } qstat_t;

endpackage

// ----- rtl/itep_ifs.sv -----
interface itep_byte_if import itep_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] table_byte;
  logic       start_of_table;

  modport source (output valid, table_byte, start_of_table, input ready);
  modport sink (input valid, table_byte, start_of_table, output ready);
endinterface

interface itep_rec_if import itep_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [5:0]  slot;
  logic [7:0]  first_id;
  logic [7:0]  second_id;
  logic [31:0] first_word;
  logic [31:0] second_word;
  logic [15:0] override_flags;
  logic        malformed;
  logic        last;

  modport source (output valid, record_kind, slot, first_id, second_id, first_word,
                  second_word, override_flags, malformed, last, input ready);
  modport sink (input valid, record_kind, slot, first_id, second_id, first_word,
                second_word, override_flags, malformed, last, output ready);
endinterface

// ----- rtl/itep_front.sv -----
module itep_front import itep_pkg::*; #(
  parameter int MaxProcessors    = MaxProcessorsDef,
  parameter int MaxIoControllers = MaxIoControllersDef,
  parameter int MaxOverrides     = MaxOverridesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  itep_byte_if.sink   table_i,
  input  qstat_t      qstat_i,
  output push_t       push_o
);

  localparam int CntPW = $clog2(MaxProcessors + 1);
  localparam int CntIW = $clog2(MaxIoControllers + 1);
  localparam int CntOW = $clog2(MaxOverrides + 1);

  logic [31:0]      pos_q, pos_d, pos_e;
  logic [31:0]      len_q, len_d, len_e;
  logic [7:0]       off_q, off_d, off_e;
  logic [7:0]       typ_q, typ_d, typ_e;
  logic [7:0]       elen_q, elen_d, elen_e;
  cap_t             cap_q, cap_d, cap_e;
  logic [CntPW-1:0] pcnt_q, pcnt_d, pcnt_e;
  logic [CntIW-1:0] icnt_q, icnt_d, icnt_e;
  logic [CntOW-1:0] ocnt_q, ocnt_d, ocnt_e;
  logic             stop_q, stop_d, stop_e;

  logic       acc, start;
  logic [7:0] b, body;
  logic       base_v, ent_v, end_v, bad, fin;
  kind_e      ent_kind;
  logic [5:0] ent_slot;
  qrec_t      base_rec, ent_rec, end_rec;

  assign table_i.ready = qstat_i.ready;
  assign acc   = table_i.valid & table_i.ready;
  assign start = table_i.start_of_table;
  assign b     = table_i.table_byte;

  always_comb begin
    // start_of_table wipes the state before this word is taken
    pos_e  = start ? '0 : pos_q;
    len_e  = start ? '0 : len_q;
    off_e  = start ? '0 : off_q;
    typ_e  = start ? '0 : typ_q;
    elen_e = start ? '0 : elen_q;
    cap_e  = start ? '0 : cap_q;
    pcnt_e = start ? '0 : pcnt_q;
    icnt_e = start ? '0 : icnt_q;
    ocnt_e = start ? '0 : ocnt_q;
    stop_e = start ? 1'b0 : stop_q;
  end

  always_comb begin
    pos_d  = pos_q;
    len_d  = len_q;
    off_d  = off_q;
    typ_d  = typ_q;
    elen_d = elen_q;
    cap_d  = cap_q;
    pcnt_d = pcnt_q;
    icnt_d = icnt_q;
    ocnt_d = ocnt_q;
    stop_d = stop_q;
    base_v   = 1'b0;
    ent_v    = 1'b0;
    end_v    = 1'b0;
    bad      = 1'b0;
    fin      = 1'b0;
    ent_kind = KIND_PROC;
    ent_slot = '0;
    body     = off_e - 8'd2;
    if (acc) begin
      pos_d  = pos_e;
      len_d  = len_e;
      off_d  = off_e;
      typ_d  = typ_e;
      elen_d = elen_e;
      cap_d  = cap_e;
      pcnt_d = pcnt_e;
      icnt_d = icnt_e;
      ocnt_d = ocnt_e;
      stop_d = stop_e;
      if (!stop_e) begin
        pos_d = pos_e + 32'd1;
        if (pos_e >= 32'(LenFirst) && pos_e <= 32'(LenLast)) begin
          len_d[{pos_e[1:0], 3'b000} +: 8] = b;
        end
        if (pos_e >= 32'(BaseFirst) && pos_e <= 32'(BaseLast)) begin
          cap_d[{2'b00, pos_e[1:0]}] = b;
        end
        if (pos_e == 32'(BaseLast)) begin
          base_v = 1'b1;
        end
        // no room for even one entry header
        if (pos_e == 32'(WalkStart - 1)) begin
          if (34'(WalkStart + MinEntry) > {2'b00, len_e}) begin
            end_v  = 1'b1;
            stop_d = 1'b1;
          end
        end
        if (pos_e >= 32'(WalkStart)) begin
          if (off_e == 8'd0) begin
            typ_d = b;
            cap_d = '0;
            off_d = 8'd1;
          end else if (off_e == 8'd1) begin
            elen_d = b;
            if (b < 8'(MinEntry) ||
                ({1'b0, pos_e} - 33'd1 + {25'd0, b}) > {1'b0, len_e}) begin
              end_v  = 1'b1;
              bad    = 1'b1;
              stop_d = 1'b1;
            end else if (b == 8'(MinEntry)) begin
              fin = 1'b1;
            end else begin
              off_d = 8'd2;
            end
          end else begin
            if (body < 8'(CapBytes)) begin
              cap_d[body[3:0]] = b;
            end
            if (({1'b0, off_e} + 9'd1) >= {1'b0, elen_e}) begin
              fin = 1'b1;
            end else begin
              off_d = off_e + 8'd1;
            end
          end
        end
        if (fin) begin
          off_d = 8'd0;
          case (typ_e)
            ENTRY_PROC: begin
              if (pcnt_e < CntPW'(MaxProcessors)) begin
                ent_v    = 1'b1;
                ent_kind = KIND_PROC;
                ent_slot = 6'(pcnt_e);
                pcnt_d   = pcnt_e + CntPW'(1);
              end
            end
            ENTRY_IOC: begin
              if (icnt_e < CntIW'(MaxIoControllers)) begin
                ent_v    = 1'b1;
                ent_kind = KIND_IOC;
                ent_slot = 6'(icnt_e);
                icnt_d   = icnt_e + CntIW'(1);
              end
            end
            ENTRY_OVR: begin
              if (ocnt_e < CntOW'(MaxOverrides)) begin
                ent_v    = 1'b1;
                ent_kind = KIND_OVR;
                ent_slot = 6'(ocnt_e);
                ocnt_d   = ocnt_e + CntOW'(1);
              end
            end
            default: ;
          endcase
          if (({2'b00, pos_e} + 34'd1 + 34'(MinEntry)) > {2'b00, len_e}) begin
            end_v  = 1'b1;
            stop_d = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    base_rec = '{kind: KIND_BASE, slot: '0, malformed: 1'b0, last: 1'b0, cap: cap_d};
    ent_rec  = '{kind: ent_kind, slot: ent_slot, malformed: 1'b0, last: 1'b0, cap: cap_d};
    end_rec  = '{kind: KIND_END, slot: '0, malformed: bad, last: 1'b1, cap: cap_d};
    push_o.cnt    = 2'({1'b0, base_v} + {1'b0, ent_v} + {1'b0, end_v});
    push_o.rec[1] = end_rec;
    if (base_v) begin
      push_o.rec[0] = base_rec;
    end else if (ent_v) begin
      push_o.rec[0] = ent_rec;
    end else begin
      push_o.rec[0] = end_rec;
    end
    push_o.rec[0].last = (push_o.cnt == 2'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      len_q  <= '0;
      off_q  <= '0;
      typ_q  <= '0;
      elen_q <= '0;
      cap_q  <= '0;
      pcnt_q <= '0;
      icnt_q <= '0;
      ocnt_q <= '0;
      stop_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      len_q  <= len_d;
      off_q  <= off_d;
      typ_q  <= typ_d;
      elen_q <= elen_d;
      cap_q  <= cap_d;
      pcnt_q <= pcnt_d;
      icnt_q <= icnt_d;
      ocnt_q <= ocnt_d;
      stop_q <= stop_d;
    end
  end

endmodule

// ----- rtl/itep_queue.sv -----
module itep_queue import itep_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output qrec_t  head_o,
  output qstat_t qstat_o
);

  qrec_t [QDepth-1:0] mem_q;
  logic [PtrW-1:0]    wp_q, wp_d, rp_q, rp_d, wp_nx;
  logic [LvlW-1:0]    lvl_q, lvl_d;
  logic               pop;

  assign pop   = pop_i & (lvl_q != '0);
  assign wp_nx = wp_q + PtrW'(1);
  assign head_o = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q + PtrW'(push_i.cnt);
    rp_d  = pop ? rp_q + PtrW'(1) : rp_q;
    lvl_d = lvl_q + LvlW'(push_i.cnt) - LvlW'(pop);
    // keep room for the two records one word can raise
    qstat_o.level    = lvl_q;
    qstat_o.ready    = (lvl_q <= LvlW'(QDepth - 2));
    qstat_o.nonempty = (lvl_q != '0);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wp_q] <= push_i.rec[0];
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wp_nx] <= push_i.rec[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      lvl_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      lvl_q <= lvl_d;
    end
  end

endmodule

// ----- rtl/itep_back.sv -----
module itep_back import itep_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  qrec_t       head_i,
  input  qstat_t      qstat_i,
  output logic        pop_o,
  itep_rec_if.source  record_o
);

  logic        vld_q, vld_d, take;
  logic [2:0]  kind_q, kind_d;
  logic [5:0]  slot_q, slot_d;
  logic [7:0]  id1_q, id1_d, id2_q, id2_d;
  logic [31:0] w1_q, w1_d, w2_q, w2_d;
  logic [15:0] fl_q, fl_d;
  logic        bad_q, bad_d, last_q, last_d;
  logic [31:0] word0, word2, word6;

  assign take  = !vld_q || record_o.ready;
  assign pop_o = take & qstat_i.nonempty;

  assign word0 = {head_i.cap[3], head_i.cap[2], head_i.cap[1], head_i.cap[0]};
  assign word2 = {head_i.cap[5], head_i.cap[4], head_i.cap[3], head_i.cap[2]};
  assign word6 = {head_i.cap[9], head_i.cap[8], head_i.cap[7], head_i.cap[6]};

  always_comb begin
    vld_d  = vld_q;
    kind_d = kind_q;
    slot_d = slot_q;
    id1_d  = id1_q;
    id2_d  = id2_q;
    w1_d   = w1_q;
    w2_d   = w2_q;
    fl_d   = fl_q;
    bad_d  = bad_q;
    last_d = last_q;
    if (take) begin
      vld_d  = qstat_i.nonempty;
      kind_d = head_i.kind;
      slot_d = head_i.slot;
      last_d = head_i.last;
      id1_d  = '0;
      id2_d  = '0;
      w1_d   = '0;
      w2_d   = '0;
      fl_d   = '0;
      bad_d  = 1'b0;
      case (head_i.kind)
        KIND_BASE: w1_d = word0;
        KIND_PROC: begin
          id1_d = head_i.cap[0];
          id2_d = head_i.cap[1];
          w1_d  = word2;
        end
        KIND_IOC: begin
          id1_d = head_i.cap[0];
          w1_d  = word2;
          w2_d  = word6;
        end
        KIND_OVR: begin
          id1_d = head_i.cap[0];
          id2_d = head_i.cap[1];
          w1_d  = word2;
          fl_d  = {head_i.cap[7], head_i.cap[6]};
        end
        KIND_END: bad_d = head_i.malformed;
        default: ;
      endcase
    end
  end

  assign record_o.valid          = vld_q;
  assign record_o.record_kind    = kind_q;
  assign record_o.slot           = slot_q;
  assign record_o.first_id       = id1_q;
  assign record_o.second_id      = id2_q;
  assign record_o.first_word     = w1_q;
  assign record_o.second_word    = w2_q;
  assign record_o.override_flags = fl_q;
  assign record_o.malformed      = bad_q;
  assign record_o.last           = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    slot_q <= slot_d;
    id1_q  <= id1_d;
    id2_q  <= id2_d;
    w1_q   <= w1_d;
    w2_q   <= w2_d;
    fl_q   <= fl_d;
    bad_q  <= bad_d;
    last_q <= last_d;
  end

endmodule

// ----- rtl/interrupt_table_entry_parser.sv -----
// Channel    Dir  Word                                   Handshake
// table_i    in   table_byte, start_of_table             valid/ready
// record_o   out  kind, slot, ids, words, flags, malformed, last  valid/ready
//
// One table byte per cycle; ready drops only while the record queue has fewer
// than two free places. Records leave one per cycle while the receiver is ready,
// passing through the queue and then an output register.
// Reset clears all parse state and the queue; start_of_table restarts a table.
// Either side may stall freely; the four-place queue parts the two sides.
`include "interrupt_table_entry_parser_assert.svh"

module interrupt_table_entry_parser import itep_pkg::*; #(
  parameter int MaxProcessors    = MaxProcessorsDef,
  parameter int MaxIoControllers = MaxIoControllersDef,
  parameter int MaxOverrides     = MaxOverridesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itep_byte_if.sink  table_i,
  itep_rec_if.source record_o
);

  push_t  push;
  qstat_t qstat;
  qrec_t  head;
  logic   pop;
  logic   push_end;

  itep_front #(
    .MaxProcessors    (MaxProcessors),
    .MaxIoControllers (MaxIoControllers),
    .MaxOverrides     (MaxOverrides)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .table_i (table_i),
    .qstat_i (qstat),
    .push_o  (push)
  );

  itep_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .qstat_o (qstat)
  );

  itep_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .qstat_i  (qstat),
    .pop_o    (pop),
    .record_o (record_o)
  );

  assign push_end = (push.cnt == 2'd2) ||
                    (push.cnt == 2'd1 && push.rec[0].kind == KIND_END);

  `ITEP_ASSERT_IMP(a_queue_bound, clk_i, rst_ni, 1'b1, qstat.level <= LvlW'(QDepth), "queue overfilled")
  `ITEP_ASSERT_IMP(a_pair_order, clk_i, rst_ni, push.cnt == 2'd2, push.rec[1].kind == KIND_END && push.rec[1].last && !push.rec[0].last, "bad record pair")
  `ITEP_ASSERT_NXT(a_quiet_after_end, clk_i, rst_ni, push_end, !(table_i.valid && table_i.ready && !table_i.start_of_table && push.cnt != 2'd0), "record after end")

endmodule

// ----- bench/interrupt_table_entry_parser_test.sv -----
`timescale 1ns / 1ps

module interrupt_table_entry_parser_test;
  import itep_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [5:0]  slot;
    logic [7:0]  first_id;
    logic [7:0]  second_id;
    logic [31:0] first_word;
    logic [31:0] second_word;
    logic [15:0] override_flags;
    logic        malformed;
    logic        last;
  } table_rec_t;

  class record_ledger;
    table_rec_t  due_records[$];
    table_rec_t  batch[$];
    int unsigned next_pos;
    logic [31:0] tbl_len;
    int          ent_idx;
    int          ent_len;
    logic [7:0]  ent_type;
    logic [7:0]  body [CapBytes];
    int          n_proc;
    int          n_ioc;
    int          n_ovr;
    bit          halted;
    int          errors;
    int          checked;
    int          tables;
    int          malformed_ends;
    int          kind_count [5];

    function new();
      restart();
    endfunction

    function void restart();
      next_pos = 0;
      tbl_len  = '0;
      ent_idx  = 0;
      ent_len  = 0;
      ent_type = '0;
      foreach (body[i]) body[i] = '0;
      n_proc = 0;
      n_ioc  = 0;
      n_ovr  = 0;
      halted = 1'b0;
    endfunction

    function logic [31:0] le32(int i);
      return {body[i+3], body[i+2], body[i+1], body[i]};
    endfunction

    function void add(kind_e k, int s, logic [7:0] a, logic [7:0] c, logic [31:0] w1,
                      logic [31:0] w2, logic [15:0] fl, logic bad);
      table_rec_t r;
      r.kind           = k;
      r.slot           = 6'(s);
      r.first_id       = a;
      r.second_id      = c;
      r.first_word     = w1;
      r.second_word    = w2;
      r.override_flags = fl;
      r.malformed      = bad;
      r.last           = 1'b0;
      batch.push_back(r);
    endfunction

    // Drop the entry once its kind is full.
    function void close_entry();
      case (ent_type)
        ENTRY_PROC: if (n_proc < MaxProcessorsDef) begin
          add(KIND_PROC, n_proc, body[0], body[1], le32(2), '0, '0, 1'b0);
          n_proc++;
        end
        ENTRY_IOC: if (n_ioc < MaxIoControllersDef) begin
          add(KIND_IOC, n_ioc, body[0], '0, le32(2), le32(6), '0, 1'b0);
          n_ioc++;
        end
        ENTRY_OVR: if (n_ovr < MaxOverridesDef) begin
          add(KIND_OVR, n_ovr, body[0], body[1], le32(2), '0, {body[7], body[6]}, 1'b0);
          n_ovr++;
        end
        default: ;
      endcase
      ent_idx = 0;
    endfunction

    function void end_if_full(longint unsigned nxt);
      if (nxt + 64'(MinEntry) > 64'(tbl_len)) begin
        add(KIND_END, 0, '0, '0, '0, '0, '0, 1'b0);
        halted = 1'b1;
      end
    endfunction

    function void take_byte(logic [7:0] b, logic sot);
      int unsigned p;
      batch.delete();
      if (sot) begin
        restart();
        tables++;
      end
      if (halted) return;
      p = next_pos;
      next_pos = p + 1;
      if (p >= LenFirst && p <= LenLast) tbl_len[(p - LenFirst) * 8 +: 8] = b;
      if (p >= BaseFirst && p <= BaseLast) body[p - BaseFirst] = b;
      if (p == BaseLast) add(KIND_BASE, 0, '0, '0, le32(0), '0, '0, 1'b0);
      if (p == WalkStart - 1) end_if_full(64'(WalkStart));
      if (p >= WalkStart) begin
        if (ent_idx == 0) begin
          ent_type = b;
          foreach (body[i]) body[i] = '0;
          ent_idx = 1;
        end else if (ent_idx == 1) begin
          ent_len = b;
          if (b < MinEntry || 64'(p) - 64'd1 + 64'(b) > 64'(tbl_len)) begin
            add(KIND_END, 0, '0, '0, '0, '0, '0, 1'b1);
            halted = 1'b1;
          end else if (b == MinEntry) begin
            close_entry();
            end_if_full(64'(p) + 64'd1);
          end else begin
            ent_idx = 2;
          end
        end else begin
          // Bytes past the capture window are walked over.
          if (ent_idx - 2 < CapBytes) body[ent_idx - 2] = b;
          if (ent_idx + 1 >= ent_len) begin
            close_entry();
            end_if_full(64'(p) + 64'd1);
          end else begin
            ent_idx++;
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) due_records.push_back(batch[i]);
    endfunction

    function void cmp(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: record %0d %s expected %0h actual %0h",
                 $time, checked, field, want, got);
        errors++;
      end
    endfunction

    function void match_record(table_rec_t got);
      table_rec_t want;
      if (due_records.size() == 0) begin
        $display("%0t: record %0d expected none actual %0h", $time, checked, got);
        errors++;
        return;
      end
      want = due_records.pop_front();
      cmp("record_kind", want.kind, got.kind);
      cmp("slot", want.slot, got.slot);
      cmp("first_id", want.first_id, got.first_id);
      cmp("second_id", want.second_id, got.second_id);
      cmp("first_word", want.first_word, got.first_word);
      cmp("second_word", want.second_word, got.second_word);
      cmp("override_flags", want.override_flags, got.override_flags);
      cmp("malformed", want.malformed, got.malformed);
      cmp("last", want.last, got.last);
      kind_count[want.kind]++;
      if (want.malformed) malformed_ends++;
      checked++;
    endfunction
  endclass

  localparam int IdleLimit = 3000;

  logic clk_i = 1'b0;
  logic rst_ni;

  itep_byte_if tbl_if ();
  itep_rec_if  rec_if ();

  interrupt_table_entry_parser dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .table_i  (tbl_if),
    .record_o (rec_if)
  );

  always #2 clk_i = ~clk_i;

  record_ledger ledger;
  logic [7:0]   tbl_q[$];
  bit           no_idle;
  int           bytes_sent;
  int           idle_cycles;

  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void put_header(logic [31:0] base);
    tbl_q.delete();
    repeat (WalkStart) tbl_q.push_back(8'($urandom));
    for (int i = 0; i < 4; i++) tbl_q[BaseFirst + i] = base[8 * i +: 8];
  endfunction

  function automatic void set_len(logic [31:0] len);
    for (int i = 0; i < 4; i++) tbl_q[LenFirst + i] = len[8 * i +: 8];
  endfunction

  function automatic void put_pair(logic [7:0] a, logic [7:0] b);
    tbl_q.push_back(a);
    tbl_q.push_back(b);
  endfunction

  function automatic void put_word(logic [31:0] w);
    for (int i = 0; i < 4; i++) tbl_q.push_back(w[8 * i +: 8]);
  endfunction

  function automatic void put_entry(logic [7:0] typ, logic [7:0] len);
    put_pair(typ, len);
    for (int i = 2; i < int'(len); i++) tbl_q.push_back(8'($urandom));
  endfunction

  function automatic logic [7:0] usual_len(logic [7:0] typ);
    case (typ)
      ENTRY_PROC: return 8'd8;
      ENTRY_IOC:  return 8'd12;
      ENTRY_OVR:  return 8'd10;
      default:    return 8'($urandom_range(2, 16));
    endcase
  endfunction

  function automatic void put_random_entry();
    int r;
    logic [7:0] typ;
    r = $urandom_range(0, 99);
    typ = r < 30 ? ENTRY_PROC : r < 55 ? ENTRY_IOC : r < 80 ? ENTRY_OVR : 8'($urandom);
    put_entry(typ, $urandom_range(0, 4) == 0 ? 8'($urandom_range(2, 24)) : usual_len(typ));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic sot);
    int gap;
    gap = pick_gap(no_idle);
    if (gap > 0) begin
      tbl_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    tbl_if.valid          <= 1'b1;
    tbl_if.table_byte     <= b;
    tbl_if.start_of_table <= sot;
    @(posedge clk_i);
    while (!tbl_if.ready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_table(input int count);
    for (int i = 0; i < count && i < tbl_q.size(); i++) send_byte(tbl_q[i], i == 0);
  endtask

  task automatic send_noise(input int n, input int sot_odds);
    repeat (n) send_byte(8'($urandom), sot_odds > 0 && $urandom_range(1, sot_odds) == 1);
  endtask

  task automatic pace_records();
    int gap;
    bit calm;
    forever begin
      calm = ($urandom_range(0, 5) == 0);
      rec_if.ready <= 1'b1;
      repeat ($urandom_range(1, calm ? 200 : 30)) @(posedge clk_i);
      gap = pick_gap(calm);
      if (gap > 0) begin
        rec_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic run_directed();
    // Stray words before any table, then a table too short for entries.
    send_noise(6, 0);
    put_header(32'hFFFF_FFFF);
    set_len(32'd0);
    send_table(tbl_q.size());
    send_noise(3, 0);

    // One of each kind at field extremes, unknown types, short and long entries,
    // and a two-byte entry that closes the table.
    put_header(32'h0);
    put_pair(ENTRY_PROC, 8'd8);
    put_pair(8'hFF, 8'h00);
    put_word(32'hFFFF_FFFF);
    put_pair(ENTRY_IOC, 8'd12);
    put_pair(8'h00, 8'hFF);
    put_word(32'hFEC0_0000);
    put_word(32'hFFFF_FFFF);
    put_pair(ENTRY_OVR, 8'd10);
    put_pair(8'hFF, 8'h00);
    put_word(32'h0);
    put_pair(8'hFF, 8'hFF);
    put_entry(8'h7F, 8'd6);
    put_entry(8'hFF, 8'd3);
    put_pair(ENTRY_OVR, 8'd5);
    put_pair(8'h09, 8'h12);
    tbl_q.push_back(8'hA5);
    put_entry(ENTRY_PROC, 8'd20);
    put_entry(ENTRY_IOC, 8'd2);
    set_len(32'(tbl_q.size()));
    send_table(tbl_q.size());

    // Entry lengths of one and zero.
    put_header($urandom);
    put_entry(ENTRY_PROC, 8'd8);
    put_pair(ENTRY_PROC, 8'd1);
    set_len(32'(tbl_q.size()) + 32'd10);
    send_table(tbl_q.size());
    put_header($urandom);
    put_pair(ENTRY_OVR, 8'd0);
    set_len(32'hFFFF_FFFF);
    send_table(tbl_q.size());

    // Entry running past the table length.
    put_header($urandom);
    put_entry(ENTRY_IOC, 8'd12);
    set_len(32'(tbl_q.size()) - 32'd1);
    send_table(tbl_q.size());

    // Room for exactly one minimal entry, then for none.
    put_header($urandom);
    put_entry(ENTRY_IOC, 8'd2);
    set_len(32'd46);
    send_table(tbl_q.size());
    put_header($urandom);
    set_len(32'd45);
    send_table(tbl_q.size());

    // Overfill every kind.
    put_header($urandom);
    repeat (MaxProcessorsDef + 1) put_entry(ENTRY_PROC, 8'd2);
    repeat (MaxIoControllersDef + 1) put_entry(ENTRY_IOC, 8'd2);
    repeat (MaxOverridesDef + 1) put_entry(ENTRY_OVR, 8'd2);
    set_len(32'(tbl_q.size()));
    send_table(tbl_q.size());

    // Restart in the middle of an entry, then in the middle of the header.
    put_header($urandom);
    put_entry(ENTRY_PROC, 8'd8);
    put_entry(ENTRY_OVR, 8'd10);
    put_entry(ENTRY_IOC, 8'd12);
    set_len(32'hFFFF_FFFF);
    send_table(tbl_q.size() - 7);
    put_header($urandom);
    send_table(20);
  endtask

  task automatic run_random();
    int r;
    int n;
    logic [7:0] typ;
    while (bytes_sent < 850) begin
      no_idle = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      put_header($urandom);
      if (r < 65) begin
        repeat ($urandom_range(0, 8)) put_random_entry();
        n = $urandom_range(0, 99);
        if (n < 60) set_len(32'(tbl_q.size()));
        else if (n < 75) set_len(32'(tbl_q.size()) + 32'd1);
        else if (n < 90) set_len(32'(tbl_q.size()) + 32'($urandom_range(2, 40)));
        else set_len($urandom);
      end else if (r < 75) begin
        typ = 8'($urandom_range(0, 2));
        repeat ($urandom_range(8, 70))
          put_entry(typ, $urandom_range(0, 3) == 0 ? usual_len(typ) : 8'd2);
        set_len(32'(tbl_q.size()));
      end else if (r < 90) begin
        repeat ($urandom_range(0, 3)) put_random_entry();
        if ($urandom_range(0, 1)) begin
          put_pair(8'($urandom), 8'($urandom_range(0, 1)));
          set_len(32'(tbl_q.size()) + 32'($urandom_range(0, 20)));
        end else begin
          put_entry(8'($urandom_range(0, 3)), 8'($urandom_range(3, 40)));
          set_len(32'(tbl_q.size()) - 32'($urandom_range(1, 3)));
        end
      end else begin
        tbl_q.delete();
        send_noise($urandom_range(1, 60), 8);
      end
      if (tbl_q.size() > 0) begin
        if ($urandom_range(0, 19) == 0) send_table($urandom_range(1, tbl_q.size()));
        else send_table(tbl_q.size());
      end
    end
  endtask

  // Score every word that crosses either channel; stop on a long silence.
  always @(posedge clk_i) begin
    table_rec_t seen;
    if (rst_ni === 1'b1) begin
      idle_cycles++;
      if (tbl_if.valid && tbl_if.ready) begin
        ledger.take_byte(tbl_if.table_byte, tbl_if.start_of_table);
        idle_cycles = 0;
      end
      if (rec_if.valid && rec_if.ready) begin
        seen.kind           = kind_e'(rec_if.record_kind);
        seen.slot           = rec_if.slot;
        seen.first_id       = rec_if.first_id;
        seen.second_id      = rec_if.second_id;
        seen.first_word     = rec_if.first_word;
        seen.second_word    = rec_if.second_word;
        seen.override_flags = rec_if.override_flags;
        seen.malformed      = rec_if.malformed;
        seen.last           = rec_if.last;
        ledger.match_record(seen);
        idle_cycles = 0;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, IdleLimit);
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    ledger      = new();
    bytes_sent  = 0;
    idle_cycles = 0;
    no_idle     = 1'b0;
    rst_ni                <= 1'b0;
    tbl_if.valid          <= 1'b0;
    tbl_if.table_byte     <= '0;
    tbl_if.start_of_table <= 1'b0;
    rec_if.ready          <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    fork
      pace_records();
    join_none
    run_directed();
    run_random();
    tbl_if.valid <= 1'b0;
    while (ledger.due_records.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("summary: %0d bytes over %0d tables, %0d records checked",
             bytes_sent, ledger.tables, ledger.checked);
    $display("summary: base %0d, processor %0d, io %0d, override %0d, end %0d (%0d malformed)",
             ledger.kind_count[KIND_BASE], ledger.kind_count[KIND_PROC],
             ledger.kind_count[KIND_IOC], ledger.kind_count[KIND_OVR],
             ledger.kind_count[KIND_END], ledger.malformed_ends);
    if (ledger.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
